/* rtl/nrts_pkg.sv */
// Shared types, codes and byte classification for the nested region token scanner.
package nrts_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int LEVEL_BITS  = $clog2(STACK_DEPTH + 1);
  localparam int LENGTH_BITS = 16;

  // item ops
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // result status
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;

  // region codes held on the context stack
  localparam logic [2:0] RG_ACT    = 3'd0;
  localparam logic [2:0] RG_ACTPCT = 3'd1;
  localparam logic [2:0] RG_ATTR   = 3'd2;
  localparam logic [2:0] RG_TYPE   = 3'd3;
  localparam logic [2:0] RG_CMT    = 3'd4;
  localparam logic [2:0] RG_NCMT   = 3'd5;

  // token kinds
  localparam logic [2:0] K_HEADER  = 3'd0;
  localparam logic [2:0] K_TYPE    = 3'd1;
  localparam logic [2:0] K_ACTION  = 3'd2;
  localparam logic [2:0] K_ATTR    = 3'd3;
  localparam logic [2:0] K_GATTR   = 3'd4;
  localparam logic [2:0] K_POST    = 3'd5;
  localparam logic [2:0] K_CMT     = 3'd6;
  localparam logic [2:0] K_NCMT    = 3'd7;

  // leaf modes
  localparam logic [3:0] LM_NONE    = 4'd0;
  localparam logic [3:0] LM_PCT     = 4'd1;
  localparam logic [3:0] LM_PAREN   = 4'd2;
  localparam logic [3:0] LM_STAR    = 4'd3;
  localparam logic [3:0] LM_IDENT   = 4'd4;
  localparam logic [3:0] LM_SKIP1   = 4'd5;
  localparam logic [3:0] LM_STR     = 4'd6;
  localparam logic [3:0] LM_STR_ESC = 4'd7;
  localparam logic [3:0] LM_CH      = 4'd8;
  localparam logic [3:0] LM_CH_END  = 4'd9;
  localparam logic [3:0] LM_CH_BS   = 4'd10;
  localparam logic [3:0] LM_CH_DEC  = 4'd11;
  localparam logic [3:0] LM_CH_HEX  = 4'd12;
  localparam logic [3:0] LM_CH_OCT  = 4'd13;
  localparam logic [3:0] LM_CH_BSQ  = 4'd14;
  localparam logic [3:0] LM_CH_BSDQ = 4'd15;

  // stack actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_PUSH = 2'd1;
  localparam logic [1:0] ACT_POP  = 2'd2;

  // bytes
  localparam logic [7:0] C_PCT    = 8'h25;
  localparam logic [7:0] C_LBRACE = 8'h7b;
  localparam logic [7:0] C_RBRACE = 8'h7d;
  localparam logic [7:0] C_STAR   = 8'h2a;
  localparam logic [7:0] C_SLASH  = 8'h2f;
  localparam logic [7:0] C_LPAREN = 8'h28;
  localparam logic [7:0] C_RPAREN = 8'h29;
  localparam logic [7:0] C_LT     = 8'h3c;
  localparam logic [7:0] C_GT     = 8'h3e;
  localparam logic [7:0] C_LBRACK = 8'h5b;
  localparam logic [7:0] C_RBRACK = 8'h5d;
  localparam logic [7:0] C_DQUOTE = 8'h22;
  localparam logic [7:0] C_SQUOTE = 8'h27;
  localparam logic [7:0] C_BSLASH = 8'h5c;
  localparam logic [7:0] C_MINUS  = 8'h2d;
  localparam logic [7:0] C_UNDER  = 8'h5f;
  localparam logic [7:0] C_SPACE  = 8'h20;
  localparam logic [7:0] C_ZERO   = 8'h30;
  localparam logic [7:0] C_SEVEN  = 8'h37;
  localparam logic [7:0] C_NINE   = 8'h39;
  localparam logic [7:0] C_LC_X   = 8'h78;
  localparam logic [7:0] C_LC_O   = 8'h6f;
  localparam logic [7:0] C_LC_N   = 8'h6e;
  localparam logic [7:0] C_LC_T   = 8'h74;
  localparam logic [7:0] C_LC_B   = 8'h62;
  localparam logic [7:0] C_LC_R   = 8'h72;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] allowed;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  kind;
    logic [15:0] length;
    logic        last_included;
  } out_item_t;

  // stack control between scanner and cell row
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [2:0] code;
  } stack_ctl_t;

  // outcome of one pass over the byte
  typedef struct packed {
    logic       ret;
    logic       tk;
    logic [1:0] act;
    logic [2:0] code;
    logic [3:0] leaf;
    logic [1:0] digit;
  } step_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= C_ZERO && c <= C_NINE;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == C_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // byte seen with no leaf mode active; always taken
  function automatic step_t region_step(input logic [2:0] top, input logic [7:0] c);
    step_t r;
    r = '0;
    r.ret  = 1'b1;
    r.tk   = 1'b1;
    r.leaf = LM_NONE;
    case (top)
      RG_ACT, RG_ACTPCT: begin
        if (c == C_LBRACE) begin
          r.act = ACT_PUSH; r.code = RG_ACT;
        end else if (c == C_RBRACE) begin
          if (top == RG_ACT) r.act = ACT_POP;
        end else if (c == C_PCT) r.leaf = LM_PCT;
        else if (c == C_DQUOTE) r.leaf = LM_STR;
        else if (c == C_SQUOTE) r.leaf = LM_CH;
        else if (c == C_LPAREN) r.leaf = LM_PAREN;
      end
      RG_TYPE: begin
        if (c == C_LPAREN) r.leaf = LM_PAREN;
        else if (c == C_GT) r.act = ACT_POP;
        else if (c == C_MINUS || c == C_LBRACK) r.leaf = LM_SKIP1;
      end
      RG_ATTR: begin
        if (c == C_LBRACK) begin
          r.act = ACT_PUSH; r.code = RG_ATTR;
        end else if (c == C_RBRACK) r.act = ACT_POP;
        else if (c == C_DQUOTE) r.leaf = LM_STR;
        else if (c == C_SQUOTE) r.leaf = LM_CH;
      end
      RG_CMT, RG_NCMT: begin
        if (top == RG_NCMT && c == C_LPAREN) r.leaf = LM_PAREN;
        else if (c == C_STAR) r.leaf = LM_STAR;
        else if (c == C_SQUOTE) r.leaf = LM_CH;
        else if (c == C_DQUOTE) r.leaf = LM_STR;
        else if (is_alpha(c) || c == C_UNDER) r.leaf = LM_IDENT;
      end
      default: ;
    endcase
    return r;
  endfunction

  // one pass of the leaf machine; ret low means the byte is looked at again
  function automatic step_t leaf_step(input logic [3:0] leaf, input logic [1:0] digit,
                                      input logic [2:0] top, input logic [7:0] c);
    step_t r;
    logic  ok;
    logic  [1:0] need;
    r = '0;
    r.leaf  = leaf;
    r.digit = digit;
    ok   = 1'b0;
    need = 2'd2;
    case (leaf)
      LM_NONE: r = region_step(top, c);
      LM_PCT: begin
        r.leaf = LM_NONE;
        if (top == RG_ACTPCT && c == C_RBRACE) begin
          r.ret = 1'b1; r.tk = 1'b1; r.act = ACT_POP;
        end
      end
      LM_PAREN: begin
        r.leaf = LM_NONE;
        if (c == C_STAR) begin
          r.ret = 1'b1; r.tk = 1'b1; r.act = ACT_PUSH; r.code = RG_NCMT;
        end
      end
      LM_STAR: begin
        r.leaf = LM_NONE;
        if (c == ((top == RG_CMT) ? C_SLASH : C_RPAREN)) begin
          r.ret = 1'b1; r.tk = 1'b1; r.act = ACT_POP;
        end
      end
      LM_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == C_UNDER || c == C_SQUOTE) begin
          r.ret = 1'b1; r.tk = 1'b1;
        end else r.leaf = LM_NONE;
      end
      LM_SKIP1: begin
        r.ret = 1'b1; r.tk = 1'b1; r.leaf = LM_NONE;
      end
      LM_STR: begin
        r.ret = 1'b1; r.tk = 1'b1;
        if (c == C_BSLASH) r.leaf = LM_STR_ESC;
        else if (c == C_DQUOTE) r.leaf = LM_NONE;
      end
      LM_STR_ESC: begin
        r.ret = 1'b1; r.tk = 1'b1; r.leaf = LM_STR;
      end
      LM_CH: begin
        r.ret = 1'b1; r.tk = 1'b1;
        if (c == C_BSLASH) r.leaf = LM_CH_BS;
        else if (c == C_SQUOTE) r.leaf = LM_NONE;
        else r.leaf = LM_CH_END;
      end
      LM_CH_END: begin
        r.leaf = LM_NONE;
        if (c == C_SQUOTE) begin
          r.ret = 1'b1; r.tk = 1'b1;
        end
      end
      LM_CH_BS: begin
        r.digit = 2'd0;
        r.ret   = 1'b1;
        r.tk    = 1'b1;
        if (is_digit(c)) r.leaf = LM_CH_DEC;
        else if (c == C_LC_X) r.leaf = LM_CH_HEX;
        else if (c == C_LC_O) r.leaf = LM_CH_OCT;
        else if (c == C_SQUOTE) r.leaf = LM_CH_BSQ;
        else if (c == C_DQUOTE) r.leaf = LM_CH_BSDQ;
        else if (c == C_BSLASH || c == C_LC_N || c == C_LC_T || c == C_LC_B ||
                 c == C_LC_R || c == C_SPACE) r.leaf = LM_CH_END;
        else begin
          r.ret = 1'b0; r.tk = 1'b0; r.leaf = LM_NONE;
        end
      end
      LM_CH_DEC, LM_CH_HEX, LM_CH_OCT: begin
        if (leaf == LM_CH_DEC) ok = is_digit(c);
        else if (leaf == LM_CH_HEX) ok = is_hex(c);
        else begin
          ok = c >= C_ZERO && c <= C_SEVEN; need = 2'd3;
        end
        if (!ok) begin
          r.leaf = LM_NONE; r.digit = 2'd0;
        end else begin
          r.ret = 1'b1; r.tk = 1'b1;
          if ({1'b0, digit} + 3'd1 >= {1'b0, need}) begin
            r.leaf = LM_CH_END; r.digit = 2'd0;
          end else r.digit = digit + 2'd1;
        end
      end
      LM_CH_BSQ: begin
        if (c == C_SQUOTE) begin
          r.ret = 1'b1; r.tk = 1'b1; r.leaf = LM_NONE;
        end else r.leaf = LM_CH;
      end
      LM_CH_BSDQ: begin
        if (c == C_SQUOTE) begin
          r.ret = 1'b1; r.tk = 1'b1; r.leaf = LM_NONE;
        end else r.leaf = LM_STR;
      end
      default: r.leaf = LM_NONE;
    endcase
    return r;
  endfunction

  // up to four passes over one byte
  function automatic step_t body_step(input logic [3:0] leaf, input logic [1:0] digit,
                                      input logic [2:0] top, input logic [7:0] c);
    step_t r;
    r = '0;
    r.leaf  = leaf;
    r.digit = digit;
    for (int it = 0; it < 4; it++) begin
      if (!r.ret) r = leaf_step(r.leaf, r.digit, top, c);
    end
    return r;
  endfunction

endpackage

/* rtl/nrts_if.sv */
// Valid/ready channel interfaces for scanner items and results.
interface nrts_in_if (input logic clk);
  logic              valid;
  logic              ready;
  nrts_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nrts_out_if (input logic clk);
  logic               valid;
  logic               ready;
  nrts_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/nrts_cell.sv */
// One entry of the context stack; shifts down on push, up on pop.
module nrts_cell (
  input  logic       clk,
  input  logic       push,
  input  logic       pop,
  input  logic [2:0] from_above,
  input  logic [2:0] from_below,
  output logic [2:0] q
);

  always_ff @(posedge clk) begin
    if (push) q <= from_above;
    else if (pop) q <= from_below;
  end

endmodule

/* rtl/nrts_stack.sv */
// Context stack as a row of shifting cells; the top sits in cell zero.
module nrts_stack (
  input  logic                 clk,
  input  nrts_pkg::stack_ctl_t ctl,
  output logic [2:0]           top
);

  logic [2:0] q [nrts_pkg::STACK_DEPTH];

  for (genvar i = 0; i < nrts_pkg::STACK_DEPTH; i++) begin : g_cell
    logic [2:0] above;
    logic [2:0] below;
    if (i == 0) begin : g_first
      assign above = ctl.code;
    end else begin : g_mid
      assign above = q[i-1];
    end
    if (i == nrts_pkg::STACK_DEPTH - 1) begin : g_last
      assign below = q[i];
    end else begin : g_inner
      assign below = q[i+1];
    end
    nrts_cell u_cell (
      .clk        (clk),
      .push       (ctl.push),
      .pop        (ctl.pop),
      .from_above (above),
      .from_below (below),
      .q          (q[i])
    );
  end

  assign top = q[0];

endmodule

/* rtl/nested_region_token_scanner.sv */
// Top level of the nested region token scanner: opener decode, leaf modes, stack, result buffer.
//
//  channel | dir | payload                               | transfer when
//  req     | in  | op, allowed, ch                       | req.valid && req.ready
//  rsp     | out | status, kind, length, last_included   | rsp.valid && rsp.ready
//
// One item per clock while req.ready is high. A token's result goes to the
// output register, or to the skid stage on a stall. The leaf-mode chain (up to
// four re-examinations of a byte) feeds the stack row, which shifts one place
// per push or pop. Synchronous reset clears control; stack cells hold no reset.
// req.ready only drops while both the output register and skid stage are full.
module nested_region_token_scanner (
  input  logic               clk,
  input  logic               rst,
  nrts_in_if.sink            req,
  nrts_out_if.source         rsp
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_SKIPWS   = 3'd1;
  localparam logic [2:0] PH_PERCENT  = 3'd2;
  localparam logic [2:0] PH_SLASH    = 3'd3;
  localparam logic [2:0] PH_LPAREN   = 3'd4;
  localparam logic [2:0] PH_BODY     = 3'd5;
  localparam logic [2:0] PH_POSTLUDE = 3'd6;

  localparam int LB = nrts_pkg::LEVEL_BITS;
  localparam int NB = nrts_pkg::LENGTH_BITS;
  localparam logic [LB-1:0] DEPTH = LB'(nrts_pkg::STACK_DEPTH);

  logic [2:0]    phase, phase_next;
  logic [7:0]    allowed_mask, allowed_mask_next;
  logic [2:0]    token_kind, token_kind_next;
  logic [LB-1:0] stack_level, stack_level_next;
  logic [3:0]    leaf_mode, leaf_mode_next;
  logic [1:0]    digit_count, digit_count_next;
  logic [NB-1:0] token_length, token_length_next;

  logic [2:0]          top;
  nrts_pkg::stack_ctl_t sctl;
  nrts_pkg::step_t     st;
  nrts_pkg::in_item_t  it;

  logic                res_v;
  nrts_pkg::out_item_t res;
  logic                fin;
  logic [1:0]          fin_status;
  logic                fin_incl;
  logic                take;
  logic                acc;

  logic                out_valid, skid_valid;
  nrts_pkg::out_item_t out_item, skid_item;

  assign it  = req.data;
  assign req.ready = !skid_valid;
  assign acc = req.valid && req.ready;

  nrts_stack u_stack (
    .clk (clk),
    .ctl (sctl),
    .top (top)
  );

  assign st = nrts_pkg::body_step(leaf_mode, digit_count, top, it.ch);

  always_comb begin
    phase_next        = phase;
    allowed_mask_next = allowed_mask;
    token_kind_next   = token_kind;
    stack_level_next  = stack_level;
    leaf_mode_next    = leaf_mode;
    digit_count_next  = digit_count;
    token_length_next = token_length;
    sctl              = '0;
    fin               = 1'b0;
    fin_status        = nrts_pkg::ST_NONE;
    fin_incl          = 1'b0;
    take              = 1'b0;

    if (acc) begin
      case (it.op)
        nrts_pkg::OP_BEGIN: begin
          allowed_mask_next = it.allowed;
          phase_next        = PH_SKIPWS;
          token_kind_next   = nrts_pkg::K_HEADER;
          stack_level_next  = '0;
          leaf_mode_next    = nrts_pkg::LM_NONE;
          digit_count_next  = 2'd0;
          token_length_next = '0;
        end
        nrts_pkg::OP_END: begin
          if (phase != PH_IDLE) begin
            fin        = 1'b1;
            fin_status = (phase == PH_BODY || phase == PH_POSTLUDE) ?
                         nrts_pkg::ST_OK : nrts_pkg::ST_NONE;
          end
        end
        nrts_pkg::OP_DATA: begin
          // opener decode: sctl.code set where a region starts
          unique case (phase)
            PH_IDLE: ;
            PH_SKIPWS: begin
              if (nrts_pkg::is_space(it.ch)) begin
              end else if (it.ch == nrts_pkg::C_PCT) begin
                take = 1'b1; phase_next = PH_PERCENT;
              end else if (it.ch == nrts_pkg::C_SLASH) begin
                take = 1'b1; phase_next = PH_SLASH;
              end else if (it.ch == nrts_pkg::C_LPAREN && allowed_mask[7]) begin
                take = 1'b1; token_kind_next = nrts_pkg::K_NCMT; phase_next = PH_LPAREN;
              end else if (it.ch == nrts_pkg::C_LT && allowed_mask[1]) begin
                take = 1'b1; token_kind_next = nrts_pkg::K_TYPE;
                sctl.push = 1'b1; sctl.code = nrts_pkg::RG_TYPE;
              end else if (it.ch == nrts_pkg::C_LBRACE && allowed_mask[2]) begin
                take = 1'b1; token_kind_next = nrts_pkg::K_ACTION;
                sctl.push = 1'b1; sctl.code = nrts_pkg::RG_ACT;
              end else if (it.ch == nrts_pkg::C_LBRACK && allowed_mask[3]) begin
                take = 1'b1; token_kind_next = nrts_pkg::K_ATTR;
                sctl.push = 1'b1; sctl.code = nrts_pkg::RG_ATTR;
              end else fin = 1'b1;
            end
            PH_PERCENT: begin
              if (it.ch == nrts_pkg::C_LBRACE && allowed_mask[0]) begin
                take = 1'b1; token_kind_next = nrts_pkg::K_HEADER;
                sctl.push = 1'b1; sctl.code = nrts_pkg::RG_ACTPCT;
              end else if (it.ch == nrts_pkg::C_LBRACK && allowed_mask[4]) begin
                take = 1'b1; token_kind_next = nrts_pkg::K_GATTR;
                sctl.push = 1'b1; sctl.code = nrts_pkg::RG_ATTR;
              end else if (it.ch == nrts_pkg::C_PCT && allowed_mask[5]) begin
                take = 1'b1; token_kind_next = nrts_pkg::K_POST; phase_next = PH_POSTLUDE;
              end else fin = 1'b1;
            end
            PH_SLASH: begin
              if (it.ch == nrts_pkg::C_STAR && allowed_mask[6]) begin
                take = 1'b1; token_kind_next = nrts_pkg::K_CMT;
                sctl.push = 1'b1; sctl.code = nrts_pkg::RG_CMT;
              end else fin = 1'b1;
            end
            PH_LPAREN: begin
              if (it.ch == nrts_pkg::C_STAR) begin
                take = 1'b1; token_kind_next = nrts_pkg::K_NCMT;
                sctl.push = 1'b1; sctl.code = nrts_pkg::RG_NCMT;
              end else fin = 1'b1;
            end
            PH_POSTLUDE: take = 1'b1;
            PH_BODY: begin
              take             = st.tk;
              leaf_mode_next   = st.leaf;
              digit_count_next = st.digit;
              if (st.act == nrts_pkg::ACT_PUSH) begin
                sctl.push = 1'b1; sctl.code = st.code;
              end else if (st.act == nrts_pkg::ACT_POP) begin
                sctl.pop = 1'b1;
                if (stack_level != '0) stack_level_next = stack_level - LB'(1);
                if (stack_level <= LB'(1)) begin
                  fin = 1'b1; fin_status = nrts_pkg::ST_OK; fin_incl = 1'b1;
                end
              end
            end
            default: phase_next = PH_IDLE;
          endcase
          // a push opens a region, or overflows when the row is full
          if (sctl.push) begin
            phase_next = PH_BODY;
            if (stack_level >= DEPTH) begin
              sctl.push = 1'b0;
              fin = 1'b1; fin_status = nrts_pkg::ST_OVER; fin_incl = 1'b1;
            end else stack_level_next = stack_level + LB'(1);
          end
        end
        default: ;
      endcase
    end

    if (take && token_length != '1) token_length_next = token_length + NB'(1);

    res_v = fin;
    res.status        = fin_status;
    res.kind          = (fin_status != nrts_pkg::ST_NONE) ? token_kind_next : 3'd0;
    res.length        = (fin_status != nrts_pkg::ST_NONE) ? 16'(token_length_next) : 16'd0;
    res.last_included = (fin_status != nrts_pkg::ST_NONE) ? fin_incl : 1'b0;
    if (fin) begin
      phase_next       = PH_IDLE;
      leaf_mode_next   = nrts_pkg::LM_NONE;
      stack_level_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      allowed_mask <= '0;
      token_kind   <= '0;
      stack_level  <= '0;
      leaf_mode    <= nrts_pkg::LM_NONE;
      digit_count  <= '0;
      token_length <= '0;
    end else begin
      phase        <= phase_next;
      allowed_mask <= allowed_mask_next;
      token_kind   <= token_kind_next;
      stack_level  <= stack_level_next;
      leaf_mode    <= leaf_mode_next;
      digit_count  <= digit_count_next;
      token_length <= token_length_next;
    end
  end

  // output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else out_valid <= res_v;
    end else if (res_v) skid_valid <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!out_valid || rsp.ready) begin
      if (skid_valid) out_item <= skid_item;
      else if (res_v) out_item <= res;
    end else if (res_v) skid_item <= res;
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid holds a result with output empty");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    stack_level <= DEPTH) else $error("stack level beyond depth");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> stack_level == '0 && leaf_mode == nrts_pkg::LM_NONE)
    else $error("idle with open regions or leaf mode");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == nrts_pkg::ST_NONE |->
      out_item.kind == 3'd0 && out_item.length == 16'd0 && !out_item.last_included)
    else $error("no-token result carries data");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

endmodule
